@@ sv/rcd_pkg.sv @@
// Package: shared types, register indexes and constants of the RC frame receiver/decoder.
package rcd_pkg;

    localparam int TimerWidth = 16;
    localparam int FrameBits  = 16;
    localparam int BitIdxW    = $clog2(FrameBits);
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 16;

    // Register indexes
    localparam logic [CfgIdxW-1:0] REG_BIT_PERIOD   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_START_DELAY  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_IDLE_TIMEOUT = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SYNC_BYTE    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ADDRESS      = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_DUTY_ONE     = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_DUTY_TWO     = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_DUTY_DEFAULT = 3'd7;

    // Reset values
    localparam logic [TimerWidth-1:0] RST_BIT_PERIOD   = 16'd5000;
    localparam logic [TimerWidth-1:0] RST_START_DELAY  = 16'd100;
    localparam logic [TimerWidth-1:0] RST_IDLE_TIMEOUT = 16'd6000;
    localparam logic [7:0]            RST_SYNC_BYTE    = 8'hA5;
    localparam logic [3:0]            RST_ADDRESS      = 4'hC;
    localparam logic [7:0]            RST_DUTY_ONE     = 8'd23;
    localparam logic [7:0]            RST_DUTY_TWO     = 8'd17;
    localparam logic [7:0]            RST_DUTY_DEFAULT = 8'd20;

    // Frame field codes
    localparam logic [1:0] SPEED_ONE = 2'b01;
    localparam logic [1:0] SPEED_TWO = 2'b10;
    localparam logic [1:0] DIR_UP    = 2'b01;
    localparam logic [1:0] DIR_DOWN  = 2'b10;

    localparam logic [TimerWidth-1:0] TIMER_MAX = {TimerWidth{1'b1}};

    typedef struct packed {
        logic [TimerWidth-1:0] bit_period;
        logic [TimerWidth-1:0] start_delay;
        logic [TimerWidth-1:0] idle_timeout;
        logic [7:0]            sync_byte;
        logic [3:0]            address;
        logic [7:0]            duty_one;
        logic [7:0]            duty_two;
        logic [7:0]            duty_default;
    } t_cfg;

    typedef struct packed {
        logic [7:0] duty_compare;
        logic       drive_up;
        logic       drive_down;
        logic       frame_accepted;
        logic       receiving;
    } t_result;

endpackage

@@ sv/rcd_cfg_regs.sv @@
// Configuration register file of the RC frame receiver/decoder.
module rcd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [rcd_pkg::CfgIdxW-1:0]   i_wr_index,
    input  logic [rcd_pkg::CfgDataW-1:0]  i_wr_data,
    output rcd_pkg::t_cfg                 o_cfg
);

    rcd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period   <= rcd_pkg::RST_BIT_PERIOD;
            r_cfg.start_delay  <= rcd_pkg::RST_START_DELAY;
            r_cfg.idle_timeout <= rcd_pkg::RST_IDLE_TIMEOUT;
            r_cfg.sync_byte    <= rcd_pkg::RST_SYNC_BYTE;
            r_cfg.address      <= rcd_pkg::RST_ADDRESS;
            r_cfg.duty_one     <= rcd_pkg::RST_DUTY_ONE;
            r_cfg.duty_two     <= rcd_pkg::RST_DUTY_TWO;
            r_cfg.duty_default <= rcd_pkg::RST_DUTY_DEFAULT;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                rcd_pkg::REG_BIT_PERIOD:   r_cfg.bit_period   <= i_wr_data;
                rcd_pkg::REG_START_DELAY:  r_cfg.start_delay  <= i_wr_data;
                rcd_pkg::REG_IDLE_TIMEOUT: r_cfg.idle_timeout <= i_wr_data;
                rcd_pkg::REG_SYNC_BYTE:    r_cfg.sync_byte    <= i_wr_data[7:0];
                rcd_pkg::REG_ADDRESS:      r_cfg.address      <= i_wr_data[3:0];
                rcd_pkg::REG_DUTY_ONE:     r_cfg.duty_one     <= i_wr_data[7:0];
                rcd_pkg::REG_DUTY_TWO:     r_cfg.duty_two     <= i_wr_data[7:0];
                rcd_pkg::REG_DUTY_DEFAULT: r_cfg.duty_default <= i_wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/rcd_core.sv @@
// Receiver state and per-tick next-state/result logic of the RC frame decoder.
module rcd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tick,
    input  logic             i_level,
    input  rcd_pkg::t_cfg    i_cfg,
    output rcd_pkg::t_result o_result
);

    logic                               r_busy;
    logic [rcd_pkg::TimerWidth-1:0]     r_wait;
    logic [rcd_pkg::BitIdxW-1:0]        r_bits_left;
    logic [rcd_pkg::FrameBits-1:0]      r_frame;
    logic [rcd_pkg::TimerWidth-1:0]     r_idle;
    logic [7:0]                         r_duty;
    logic                               r_up;
    logic                               r_down;

    logic                               n_busy;
    logic [rcd_pkg::TimerWidth-1:0]     n_wait;
    logic [rcd_pkg::BitIdxW-1:0]        n_bits_left;
    logic [rcd_pkg::FrameBits-1:0]      n_frame;
    logic [rcd_pkg::TimerWidth-1:0]     n_idle;
    logic [7:0]                         n_duty;
    logic                               n_up;
    logic                               n_down;
    logic                               n_accepted;

    logic [rcd_pkg::TimerWidth-1:0]     period_load;
    logic [rcd_pkg::TimerWidth-1:0]     wait_dec;
    logic                               do_check;
    logic                               frame_match;

    assign period_load = (i_cfg.bit_period == '0) ? rcd_pkg::TimerWidth'(1) : i_cfg.bit_period;
    assign wait_dec    = (r_wait != '0) ? r_wait - 1'b1 : r_wait;

    always_comb begin
        n_busy      = r_busy;
        n_wait      = r_wait;
        n_bits_left = r_bits_left;
        n_frame     = r_frame;
        n_idle      = r_idle;
        n_duty      = r_duty;
        n_up        = r_up;
        n_down      = r_down;
        do_check    = 1'b0;
        n_accepted  = 1'b0;

        if (r_busy) begin
            n_wait = wait_dec;
            if (wait_dec == '0) begin
                if (r_bits_left == '0) begin
                    n_bits_left = rcd_pkg::BitIdxW'(1);
                    n_wait      = period_load;
                end else begin
                    n_frame[r_bits_left] = i_level;
                    if (r_bits_left == rcd_pkg::BitIdxW'(rcd_pkg::FrameBits - 1)) begin
                        n_busy      = 1'b0;
                        n_bits_left = '0;
                        do_check    = 1'b1;
                    end else begin
                        n_bits_left = r_bits_left + 1'b1;
                        n_wait      = period_load;
                    end
                end
            end
        end else begin
            // timeout back to the safe state
            if (r_idle > i_cfg.idle_timeout) begin
                n_idle       = '0;
                n_frame[7:0] = 8'h01;
                n_up         = 1'b0;
                n_down       = 1'b0;
                n_duty       = i_cfg.duty_default;
            end
            if (n_idle != rcd_pkg::TIMER_MAX) begin
                n_idle = n_idle + 1'b1;
            end
            if (i_level) begin
                n_idle       = '0;
                n_frame[7:0] = 8'h01;
                n_busy       = 1'b1;
                if (i_cfg.start_delay == '0) begin
                    n_bits_left = rcd_pkg::BitIdxW'(1);
                    n_wait      = period_load;
                end else begin
                    n_bits_left = '0;
                    n_wait      = i_cfg.start_delay;
                end
            end else begin
                do_check = 1'b1;
            end
        end

        frame_match = (n_frame[7:0] == i_cfg.sync_byte) && (n_frame[11:8] == i_cfg.address);
        if (do_check && frame_match) begin
            unique case (n_frame[13:12])
                rcd_pkg::SPEED_ONE: n_duty = i_cfg.duty_one;
                rcd_pkg::SPEED_TWO: n_duty = i_cfg.duty_two;
                default:            n_duty = i_cfg.duty_default;
            endcase
            n_up       = (n_frame[15:14] == rcd_pkg::DIR_UP);
            n_down     = (n_frame[15:14] == rcd_pkg::DIR_DOWN);
            // only the last-bit check reports a new frame
            n_accepted = r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_wait      <= '0;
            r_bits_left <= '0;
            r_frame     <= rcd_pkg::FrameBits'(1);
            r_idle      <= '0;
            r_duty      <= rcd_pkg::RST_DUTY_DEFAULT;
            r_up        <= 1'b0;
            r_down      <= 1'b0;
        end else if (i_tick) begin
            r_busy      <= n_busy;
            r_wait      <= n_wait;
            r_bits_left <= n_bits_left;
            r_frame     <= n_frame;
            r_idle      <= n_idle;
            r_duty      <= n_duty;
            r_up        <= n_up;
            r_down      <= n_down;
        end
    end

    assign o_result.duty_compare   = n_duty;
    assign o_result.drive_up       = n_up;
    assign o_result.drive_down     = n_down;
    assign o_result.frame_accepted = n_accepted;
    assign o_result.receiving      = n_busy;

endmodule

@@ sv/rc_frame_receiver_decoder_top.sv @@
// Top level of the RC frame receiver/decoder: handshakes, config port and result register.
//
// One input transfer is one tick of the sampled radio line; every tick yields
// exactly one result transfer carrying the PWM compare value, the two drive
// outputs, a one-tick frame_accepted pulse and the receiving flag. The block
// takes one tick per clock cycle while the output is not stalled: the
// receiver state and the output register both load at the edge that accepts
// the tick. A new tick is accepted whenever the output register is empty or
// is being emptied in the same cycle, so throughput is one tick per cycle
// while the result side does not stall. Configuration writes are always
// ready and must only be issued while no result is pending. Frames start on
// a high line while idle; bit 0 is implied, bits 1..15 are sampled at
// start_delay plus k times bit_period ticks. A frame updates the outputs
// when its low byte matches sync_byte and bits 11:8 match address. Too many
// idle ticks return the outputs to stop with the default duty.
module rc_frame_receiver_decoder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tick input
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_rf_level,
    // result output
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_duty_compare,
    output logic                          o_drive_up,
    output logic                          o_drive_down,
    output logic                          o_frame_accepted,
    output logic                          o_receiving,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rcd_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [rcd_pkg::CfgDataW-1:0]  i_cfg_data
);

    rcd_pkg::t_cfg    cfg;
    rcd_pkg::t_result result;
    rcd_pkg::t_result r_out;
    logic             r_out_valid;
    logic             tick;

    // input stalls only while a finished result is held back downstream
    assign o_stall     = r_out_valid & i_stall;
    assign tick        = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;

    rcd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    rcd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick),
        .i_level  (i_rf_level),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_duty_compare   = r_out.duty_compare;
    assign o_drive_up       = r_out.drive_up;
    assign o_drive_down     = r_out.drive_down;
    assign o_frame_accepted = r_out.frame_accepted;
    assign o_receiving      = r_out.receiving;

endmodule

@@ bench/rc_frame_receiver_decoder_top_tb.sv @@
// Self-checking testbench for the RC frame receiver/decoder: tick stream, register setups, result checks.
module rc_frame_receiver_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Field codes the package leaves unnamed: both fall back to stop / default duty
    localparam logic [1:0] SPEED_DEF = 2'b00;
    localparam logic [1:0] SPEED_ALT = 2'b11;
    localparam logic [1:0] DIR_STOP  = 2'b00;
    localparam logic [1:0] DIR_BOTH  = 2'b11;

    localparam int unsigned CycleLimit = 20_000;
    localparam int unsigned GapPct     = 29;
    localparam int unsigned MaxReports = 20;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic                         i_rf_level = 1'b0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic [7:0]                   o_duty_compare;
    logic                         o_drive_up;
    logic                         o_drive_down;
    logic                         o_frame_accepted;
    logic                         o_receiving;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [rcd_pkg::CfgIdxW-1:0]  i_cfg_index = '0;
    logic [rcd_pkg::CfgDataW-1:0] i_cfg_data = '0;

    rc_frame_receiver_decoder_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rf_level       (i_rf_level),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_duty_compare   (o_duty_compare),
        .o_drive_up       (o_drive_up),
        .o_drive_down     (o_drive_down),
        .o_frame_accepted (o_frame_accepted),
        .o_receiving      (o_receiving),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    logic             rf_ticks_q[$];          // line levels still to be sent
    rcd_pkg::t_result motor_outputs_due[$];   // predicted results, oldest first
    int unsigned ticks_queued   = 0;
    int unsigned ticks_taken    = 0;
    int unsigned good_frames    = 0;
    int unsigned frames_decoded = 0;
    int unsigned settings       = 0;
    int unsigned failures       = 0;
    int unsigned cycle_count    = 0;
    bit          no_gaps        = 1'b0;  // suppresses random idling on both sides
    logic        tick_taken     = 1'b0;

    // ------------------------------------------------------------------
    // Decoder mirror: register copy plus receiver state, reset values
    // ------------------------------------------------------------------
    rcd_pkg::t_cfg cfg_mirror = '{
        bit_period:   rcd_pkg::RST_BIT_PERIOD,
        start_delay:  rcd_pkg::RST_START_DELAY,
        idle_timeout: rcd_pkg::RST_IDLE_TIMEOUT,
        sync_byte:    rcd_pkg::RST_SYNC_BYTE,
        address:      rcd_pkg::RST_ADDRESS,
        duty_one:     rcd_pkg::RST_DUTY_ONE,
        duty_two:     rcd_pkg::RST_DUTY_TWO,
        duty_default: rcd_pkg::RST_DUTY_DEFAULT
    };

    logic        rx_busy  = 1'b0;
    logic [15:0] rx_wait  = '0;
    logic [3:0]  rx_bit   = '0;       // 0: start delay running, else next bit position
    logic [15:0] rx_word  = 16'h0001;
    logic [15:0] rx_idle  = '0;
    logic [7:0]  out_duty = rcd_pkg::RST_DUTY_DEFAULT;
    logic        out_up   = 1'b0;
    logic        out_down = 1'b0;

    // Applies the frame word to the outputs when sync and address match.
    function automatic logic frame_matches();
        logic [1:0] speed;
        logic [1:0] dir;
        if (rx_word[7:0] != cfg_mirror.sync_byte || rx_word[11:8] != cfg_mirror.address)
            return 1'b0;
        speed = rx_word[13:12];
        dir   = rx_word[15:14];
        if (speed == rcd_pkg::SPEED_ONE)
            out_duty = cfg_mirror.duty_one;
        else if (speed == rcd_pkg::SPEED_TWO)
            out_duty = cfg_mirror.duty_two;
        else
            out_duty = cfg_mirror.duty_default;
        out_up   = (dir == rcd_pkg::DIR_UP);
        out_down = (dir == rcd_pkg::DIR_DOWN);
        return 1'b1;
    endfunction

    // Advances the mirror by one line tick and returns the outputs it yields.
    function automatic rcd_pkg::t_result receiver_tick(input logic level);
        rcd_pkg::t_result r;
        logic             accepted;
        logic [15:0]      per;
        accepted = 1'b0;
        // a zero period behaves as one tick
        per = (cfg_mirror.bit_period == '0) ? 16'd1 : cfg_mirror.bit_period;
        if (rx_busy) begin
            if (rx_wait != '0)
                rx_wait = rx_wait - 1'b1;
            if (rx_wait == '0) begin
                if (rx_bit == '0) begin
                    rx_bit  = 4'd1;
                    rx_wait = per;
                end else begin
                    rx_word[rx_bit] = level;
                    if (rx_bit == 4'd15) begin
                        rx_busy  = 1'b0;
                        rx_bit   = '0;
                        accepted = frame_matches();
                    end else begin
                        rx_bit  = rx_bit + 1'b1;
                        rx_wait = per;
                    end
                end
            end
        end else begin
            // idle too long: safe state, and the sync byte is wiped
            if (rx_idle > cfg_mirror.idle_timeout) begin
                rx_idle      = '0;
                rx_word[7:0] = 8'h01;
                out_up       = 1'b0;
                out_down     = 1'b0;
                out_duty     = cfg_mirror.duty_default;
            end
            if (rx_idle != rcd_pkg::TIMER_MAX)
                rx_idle = rx_idle + 1'b1;
            if (level) begin
                rx_idle      = '0;
                rx_word[7:0] = 8'h01;   // bit 0 is implied by the start
                rx_busy      = 1'b1;
                rx_bit       = '0;
                rx_wait      = cfg_mirror.start_delay;
                if (rx_wait == '0) begin
                    rx_bit  = 4'd1;
                    rx_wait = per;
                end
            end else begin
                // every quiet idle tick re-evaluates the held frame
                void'(frame_matches());
            end
        end
        r.duty_compare   = out_duty;
        r.drive_up       = out_up;
        r.drive_down     = out_down;
        r.frame_accepted = accepted;
        r.receiving      = rx_busy;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            failures++;
            if (failures <= MaxReports)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Rising edge: result check, register mirror, prediction per transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        rcd_pkg::t_result want;
        if (i_rst_n) begin
            tick_taken <= i_valid && !o_stall;
            if (o_valid && !i_stall) begin
                if (motor_outputs_due.size() == 0) begin
                    failures++;
                    $display("%0t ns: result transfer with no tick outstanding", $time);
                end else begin
                    want = motor_outputs_due.pop_front();
                    check_field("duty_compare", want.duty_compare, o_duty_compare);
                    check_field("drive_up", 8'(want.drive_up), 8'(o_drive_up));
                    check_field("drive_down", 8'(want.drive_down), 8'(o_drive_down));
                    check_field("frame_accepted", 8'(want.frame_accepted),
                                8'(o_frame_accepted));
                    check_field("receiving", 8'(want.receiving), 8'(o_receiving));
                    if (o_frame_accepted === 1'b1)
                        frames_decoded++;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rcd_pkg::REG_BIT_PERIOD:   cfg_mirror.bit_period   = i_cfg_data;
                    rcd_pkg::REG_START_DELAY:  cfg_mirror.start_delay  = i_cfg_data;
                    rcd_pkg::REG_IDLE_TIMEOUT: cfg_mirror.idle_timeout = i_cfg_data;
                    rcd_pkg::REG_SYNC_BYTE:    cfg_mirror.sync_byte    = i_cfg_data[7:0];
                    rcd_pkg::REG_ADDRESS:      cfg_mirror.address      = i_cfg_data[3:0];
                    rcd_pkg::REG_DUTY_ONE:     cfg_mirror.duty_one     = i_cfg_data[7:0];
                    rcd_pkg::REG_DUTY_TWO:     cfg_mirror.duty_two     = i_cfg_data[7:0];
                    rcd_pkg::REG_DUTY_DEFAULT: cfg_mirror.duty_default = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                motor_outputs_due.push_back(receiver_tick(i_rf_level));
                ticks_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Falling edge: tick driver and result-side backpressure
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || tick_taken) begin
            // previous transfer done (or none): maybe present the next tick
            if (rf_ticks_q.size() != 0 && (no_gaps || $urandom_range(99) >= GapPct)) begin
                i_valid    <= 1'b1;
                i_rf_level <= rf_ticks_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= i_rst_n && !no_gaps && ($urandom_range(99) < GapPct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, motor_outputs_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_tick(input logic level);
        rf_ticks_q.push_back(level);
        ticks_queued++;
    endtask

    task automatic push_run(input int unsigned n, input bit noisy);
        int unsigned i;
        for (i = 0; i < n; i++)
            push_tick(noisy ? 1'($urandom_range(1)) : 1'b0);
    endtask

    // Start tick, then bits 1..15 at delay + k * period; line is random elsewhere
    task automatic push_frame(input logic [15:0] fw);
        int unsigned per;
        int unsigned dly;
        int unsigned t;
        per = (cfg_mirror.bit_period == '0) ? 1 : cfg_mirror.bit_period;
        dly = cfg_mirror.start_delay;
        push_tick(1'b1);
        for (t = 1; t <= dly + 15 * per; t++) begin
            if (t > dly && (t - dly) % per == 0)
                push_tick(fw[(t - dly) / per]);
            else
                push_tick(1'($urandom_range(1)));
        end
    endtask

    // Holds off until every queued tick went out and every result came back
    task automatic drain_pipeline();
        while (ticks_taken != ticks_queued || motor_outputs_due.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rcd_pkg::CfgIdxW-1:0] idx,
                             input logic [rcd_pkg::CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Full register setup; spare upper data bits carry junk the block must drop
    task automatic apply_setting(input logic [15:0] per, input logic [15:0] dly,
                                 input logic [15:0] tmo, input logic [7:0] sync,
                                 input logic [3:0] addr, input logic [7:0] d1,
                                 input logic [7:0] d2, input logic [7:0] dd);
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(rcd_pkg::REG_BIT_PERIOD, per);
        write_reg(rcd_pkg::REG_START_DELAY, dly);
        write_reg(rcd_pkg::REG_IDLE_TIMEOUT, tmo);
        write_reg(rcd_pkg::REG_SYNC_BYTE, {junk[15:8], sync});
        write_reg(rcd_pkg::REG_ADDRESS, {junk[11:0], addr});
        write_reg(rcd_pkg::REG_DUTY_ONE, {junk[7:0], d1});
        write_reg(rcd_pkg::REG_DUTY_TWO, {junk[13:6], d2});
        write_reg(rcd_pkg::REG_DUTY_DEFAULT, {junk[9:2], dd});
        settings++;
    endtask

    function automatic logic [7:0] pick_duty();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // One random setting with short timing, then mostly well-formed frames
    task automatic random_phase(input bit pause_midway);
        int unsigned first;
        int unsigned r;
        int unsigned per;
        bit          paused;
        logic [15:0] fw;
        logic [15:0] per_w;
        logic [15:0] dly_w;
        logic [15:0] tmo_w;
        logic [7:0]  sync;
        logic [3:0]  addr;
        per_w = 16'($urandom_range(3));
        dly_w = 16'($urandom_range(4));
        tmo_w = 16'($urandom_range(30));
        if ($urandom_range(5) == 0)
            tmo_w = 16'hFFFF;
        sync = 8'($urandom);
        // bit 0 of a frame is always 1, so an even sync byte never matches
        if ($urandom_range(7) != 0)
            sync[0] = 1'b1;
        addr = 4'($urandom);
        apply_setting(per_w, dly_w, tmo_w, sync, addr, pick_duty(), pick_duty(), pick_duty());
        paused = 1'b0;
        first  = ticks_queued;
        while (ticks_queued - first < 50) begin
            if (pause_midway && !paused && ticks_queued - first >= 25) begin
                drain_pipeline();
                paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 75) begin
                fw       = 16'($urandom);
                fw[11:0] = {addr, sync};
                if (r < 60)
                    good_frames++;
                else
                    fw = fw ^ (16'd1 << $urandom_range(11, 1));   // corrupt sync/address
                push_frame(fw);
            end else if (r < 90) begin
                push_run((tmo_w < 40) ? $urandom_range(tmo_w + 3) : $urandom_range(12), 1'b0);
            end else begin
                push_run($urandom_range(8, 1), 1'b1);
            end
        end
        // quiet tail long enough to finish any frame the noise started
        per = (per_w == '0) ? 1 : per_w;
        push_run(dly_w + 15 * per + 2, 1'b0);
        drain_pipeline();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        int unsigned n;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: quiet line, no timeout at 6000
        push_run(3, 1'b0);
        drain_pipeline();

        // Zero period (one tick), no start delay, short timeout, duty extremes.
        // Every speed and direction code, back-to-back frames, re-check on idle,
        // timeout to safe state, then a bad sync and a bad address.
        apply_setting(16'd0, 16'd0, 16'd3, 8'hA5, 4'hC, 8'd0, 8'd255, 8'h80);
        push_run(2, 1'b0);
        push_frame({DIR_BOTH, SPEED_DEF, 12'hCA5});
        push_run(1, 1'b0);
        push_frame({rcd_pkg::DIR_UP, rcd_pkg::SPEED_ONE, 12'hCA5});
        push_frame({rcd_pkg::DIR_DOWN, rcd_pkg::SPEED_TWO, 12'hCA5});
        push_run(2, 1'b0);
        push_frame({DIR_STOP, SPEED_ALT, 12'hCA5});
        push_run(1, 1'b0);
        push_frame({rcd_pkg::DIR_UP, rcd_pkg::SPEED_TWO, 12'hCA5});
        push_run(6, 1'b0);
        push_frame({rcd_pkg::DIR_DOWN, rcd_pkg::SPEED_ONE, 12'hC25});
        push_frame({rcd_pkg::DIR_DOWN, rcd_pkg::SPEED_ONE, 12'hDA5});
        push_run(2, 1'b0);
        good_frames += 5;
        drain_pipeline();

        // Zero timeout with sync byte 01: the wiped low byte still matches,
        // so the held frame overrides the safe state again on every idle tick
        apply_setting(16'd2, 16'd3, 16'd0, 8'h01, 4'h0, 8'd255, 8'd0, 8'h55);
        push_frame({rcd_pkg::DIR_DOWN, rcd_pkg::SPEED_ONE, 12'h001});
        push_run(5, 1'b0);
        good_frames++;
        drain_pipeline();

        // Random settings; the second pauses midway, the third runs with no idling
        for (n = 0; n < 3; n++) begin
            no_gaps = (n == 2);
            random_phase(n == 1);
        end

        // Longest bit period and timeout, all-ones sync and address: the frame
        // sits in its first bit period and line noise is ignored
        no_gaps = 1'b1;
        apply_setting(16'hFFFF, 16'd2, 16'hFFFF, 8'hFF, 4'hF, 8'd9, 8'd200, 8'd77);
        push_tick(1'b1);
        push_run(12, 1'b1);
        drain_pipeline();

        repeat (4) @(posedge i_clk);
        $display("Covered %0d line ticks over %0d register settings, %0d well-formed frames",
                 ticks_taken, settings, good_frames);
        $display("Decoder accepted %0d frames, %0d mismatches seen", frames_decoded, failures);
        if (failures == 0 && motor_outputs_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
sv/rcd_pkg.sv
sv/rcd_cfg_regs.sv
sv/rcd_core.sv
sv/rc_frame_receiver_decoder_top.sv
bench/rc_frame_receiver_decoder_top_tb.sv
